### sv/dsc_pkg.sv
package dsc_pkg;

	localparam int OP_W  = 6;
	localparam int CNT_W = 33;

	localparam logic [OP_W-1:0] OP_NONE      = 6'd0;
	localparam logic [OP_W-1:0] OP_LOAD      = 6'd1;
	localparam logic [OP_W-1:0] OP_EU_DIV    = 6'd2;
	localparam logic [OP_W-1:0] OP_EU_MUL    = 6'd3;
	localparam logic [OP_W-1:0] OP_EU_UPD    = 6'd4;
	localparam logic [OP_W-1:0] OP_CM_DIV    = 6'd5;
	localparam logic [OP_W-1:0] OP_CM_SAVE   = 6'd6;
	localparam logic [OP_W-1:0] OP_A_DIV     = 6'd7;
	localparam logic [OP_W-1:0] OP_A_SAVE    = 6'd8;
	localparam logic [OP_W-1:0] OP_B_DIV     = 6'd9;
	localparam logic [OP_W-1:0] OP_B_SAVE    = 6'd10;
	localparam logic [OP_W-1:0] OP_S_DIV     = 6'd11;
	localparam logic [OP_W-1:0] OP_S_SAVE    = 6'd12;
	localparam logic [OP_W-1:0] OP_G_DIV     = 6'd13;
	localparam logic [OP_W-1:0] OP_G_SAVE    = 6'd14;
	localparam logic [OP_W-1:0] OP_U_MUL     = 6'd15;
	localparam logic [OP_W-1:0] OP_U_DIV     = 6'd16;
	localparam logic [OP_W-1:0] OP_U_SAVE    = 6'd17;
	localparam logic [OP_W-1:0] OP_X_MUL     = 6'd18;
	localparam logic [OP_W-1:0] OP_Y_DIV     = 6'd19;
	localparam logic [OP_W-1:0] OP_Y_SAVE    = 6'd20;
	localparam logic [OP_W-1:0] OP_K1_DIV    = 6'd21;
	localparam logic [OP_W-1:0] OP_K1_SAVE   = 6'd22;
	localparam logic [OP_W-1:0] OP_K2_DIV    = 6'd23;
	localparam logic [OP_W-1:0] OP_K2_SAVE   = 6'd24;
	localparam logic [OP_W-1:0] OP_K3_DIV    = 6'd25;
	localparam logic [OP_W-1:0] OP_K3_SAVE   = 6'd26;
	localparam logic [OP_W-1:0] OP_K4_DIV    = 6'd27;
	localparam logic [OP_W-1:0] OP_K4_SAVE   = 6'd28;
	localparam logic [OP_W-1:0] OP_RES_ZERO  = 6'd29;
	localparam logic [OP_W-1:0] OP_RES_NOSOL = 6'd30;
	localparam logic [OP_W-1:0] OP_RES_FIXA  = 6'd31;
	localparam logic [OP_W-1:0] OP_RES_FIXB  = 6'd32;
	localparam logic [OP_W-1:0] OP_RES_SPAN  = 6'd33;

	localparam logic [1:0] ST_FINITE = 2'd0;
	localparam logic [1:0] ST_NONE   = 2'd1;
	localparam logic [1:0] ST_INF    = 2'd2;

	typedef struct packed {
		logic [OP_W-1:0] op;
	} cmd_t;

	typedef struct packed {
		logic a_zero;
		logic b_zero;
		logic c_zero;
		logic r1_zero;
		logic rem_zero;
		logic div_done;
	} stat_t;

endpackage

### sv/dsc_div.sv
module dsc_div #(
	parameter int UW = 64,
	parameter int SW = 34
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic                 long_op,
	input  logic [UW-1:0]        n_mag,
	input  logic                 n_neg,
	input  logic [UW-1:0]        d_mag,
	input  logic                 d_neg,
	output logic                 done,
	output logic                 rem_zero,
	output logic signed [UW+1:0] q_trunc,
	output logic signed [UW+1:0] q_floor,
	output logic signed [UW+1:0] q_ceil,
	output logic signed [UW+1:0] r_mod
);

	localparam int CW = $clog2(UW + 1);

	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [UW-1:0] dvd_q;
	logic [UW-1:0] rem_q;
	logic [UW-1:0] dsr_q;
	logic          nneg_q;
	logic          dneg_q;
	logic [UW:0]   trial;
	logic          rnz;
	logic          differ;
	logic signed [UW+1:0] qs;
	logic signed [UW+1:0] rnz_ext;

	assign trial = {rem_q, dvd_q[UW-1]} - {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= long_op ? CW'(UW) : CW'(SW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q  <= long_op ? n_mag : (n_mag << (UW - SW));
			rem_q  <= '0;
			dsr_q  <= d_mag;
			nneg_q <= n_neg;
			dneg_q <= d_neg;
		end else if (busy_q) begin
			if (!trial[UW]) begin
				rem_q <= trial[UW-1:0];
				dvd_q <= {dvd_q[UW-2:0], 1'b1};
			end else begin
				rem_q <= {rem_q[UW-2:0], dvd_q[UW-1]};
				dvd_q <= {dvd_q[UW-2:0], 1'b0};
			end
		end
	end

	assign rnz      = |rem_q;
	assign differ   = nneg_q ^ dneg_q;
	assign qs       = {2'b00, dvd_q};
	assign rnz_ext  = {{(UW+1){1'b0}}, rnz};
	assign done     = done_q;
	assign rem_zero = !rnz;
	assign q_trunc  = differ ? -qs : qs;
	assign q_floor  = differ ? (-qs - rnz_ext) : qs;
	assign q_ceil   = differ ? -qs : (qs + rnz_ext);
	assign r_mod    = (nneg_q && rnz) ? {2'b00, dsr_q - rem_q} : {2'b00, rem_q};

`ifndef SYNTH
	a_start_clears_done: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> !done) else $error("divider done right after start");
`endif

endmodule

### sv/dsc_dp.sv
module dsc_dp #(
	parameter int W = 32
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  dsc_pkg::cmd_t                   cmd,
	input  logic signed [W-1:0]             coef_a,
	input  logic signed [W-1:0]             coef_b,
	input  logic signed [W-1:0]             rhs_c,
	input  logic signed [W-1:0]             x_low,
	input  logic signed [W-1:0]             x_high,
	input  logic signed [W-1:0]             y_low,
	input  logic signed [W-1:0]             y_high,
	output dsc_pkg::stat_t                  stat,
	output logic [1:0]                      status,
	output logic [dsc_pkg::CNT_W-1:0]       solution_count
);

	localparam int UW = 2 * W;
	localparam int DW = 2 * W + 2;
	localparam int SW = W + 2;
	localparam int CW = dsc_pkg::CNT_W;

	function automatic logic signed [DW-1:0] sx(input logic [W-1:0] v);
		return {{(DW-W){v[W-1]}}, v};
	endfunction

	function automatic logic [UW-1:0] mag(input logic signed [DW-1:0] v);
		logic signed [DW-1:0] nv;
		nv = -v;
		return v[DW-1] ? nv[UW-1:0] : v[UW-1:0];
	endfunction

	function automatic logic [CW-1:0] span(input logic signed [DW-1:0] lo,
		input logic signed [DW-1:0] hi);
		logic signed [DW-1:0] d;
		d = hi - lo + DW'(1);
		return (lo > hi) ? '0 : CW'(d);
	endfunction

	logic signed [W-1:0]  a_q, b_q, c_q, xl_q, xh_q, yl_q, yh_q;
	logic [W-1:0]         r0_q, r1_q;
	logic signed [W:0]    s0_q, s1_q;
	logic signed [DW-1:0] prod_q, cg_q, ap_q, bp_q, pm1_q, pm2_q, x0_q, y0_q;
	logic signed [DW-1:0] kmin_q, kmax_q;
	logic [1:0]           status_q;
	logic [CW-1:0]        count_q;

	logic signed [DW-1:0] ae, be, ce, xle, xhe, yle, yhe, s0e, r0e, r1e;
	logic signed [DW-1:0] nxl, nxh, nyl, nyh, fix_v;
	logic signed [DW-1:0] div_n, div_d;
	logic                 div_start, div_long;
	logic signed [W:0]    mul_x, mul_y;
	logic signed [DW-1:0] product;
	logic                 div_done, rem_zero;
	logic signed [DW-1:0] q_trunc, q_floor, q_ceil, r_mod;

	assign ae  = sx(a_q);
	assign be  = sx(b_q);
	assign ce  = sx(c_q);
	assign xle = sx(xl_q);
	assign xhe = sx(xh_q);
	assign yle = sx(yl_q);
	assign yhe = sx(yh_q);
	assign s0e = {{(DW-W-1){s0_q[W]}}, s0_q};
	assign r0e = {{(DW-W){1'b0}}, r0_q};
	assign r1e = {{(DW-W){1'b0}}, r1_q};
	assign nxl = xle - x0_q;
	assign nxh = xhe - x0_q;
	assign nyl = yle - y0_q;
	assign nyh = yhe - y0_q;

	always_comb begin
		div_n     = '0;
		div_d     = r0e;
		div_start = 1'b1;
		div_long  = 1'b0;
		unique case (cmd.op)
			dsc_pkg::OP_EU_DIV: begin
				div_n = r0e;
				div_d = r1e;
			end
			dsc_pkg::OP_CM_DIV: div_n = ce;
			dsc_pkg::OP_A_DIV:  div_n = ae;
			dsc_pkg::OP_B_DIV:  div_n = be;
			dsc_pkg::OP_S_DIV: begin
				div_n = s0e;
				div_d = bp_q;
			end
			dsc_pkg::OP_G_DIV: begin
				div_n = cg_q;
				div_d = bp_q;
			end
			dsc_pkg::OP_U_DIV: begin
				div_n    = prod_q;
				div_d    = bp_q;
				div_long = 1'b1;
			end
			dsc_pkg::OP_Y_DIV: begin
				div_n    = ce - prod_q;
				div_d    = be;
				div_long = 1'b1;
			end
			dsc_pkg::OP_K1_DIV: begin
				div_n = bp_q[DW-1] ? nxh : nxl;
				div_d = bp_q;
			end
			dsc_pkg::OP_K2_DIV: begin
				div_n = bp_q[DW-1] ? nxl : nxh;
				div_d = bp_q;
			end
			dsc_pkg::OP_K3_DIV: begin
				div_n = ap_q[DW-1] ? nyl : nyh;
				div_d = -ap_q;
			end
			dsc_pkg::OP_K4_DIV: begin
				div_n = ap_q[DW-1] ? nyh : nyl;
				div_d = -ap_q;
			end
			default: div_start = 1'b0;
		endcase
	end

	always_comb begin
		mul_x = q_trunc[W:0];
		mul_y = s1_q;
		unique case (cmd.op)
			dsc_pkg::OP_U_MUL: begin
				mul_x = pm1_q[W:0];
				mul_y = pm2_q[W:0];
			end
			dsc_pkg::OP_X_MUL: begin
				mul_x = ae[W:0];
				mul_y = x0_q[W:0];
			end
			default: begin
				mul_x = q_trunc[W:0];
				mul_y = s1_q;
			end
		endcase
	end

	assign product = mul_x * mul_y;
	assign fix_v   = (cmd.op == dsc_pkg::OP_RES_FIXA) ?
		(b_q[W-1] ? -cg_q : cg_q) : (a_q[W-1] ? -cg_q : cg_q);

	dsc_div #(.UW(UW), .SW(SW)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.long_op  (div_long),
		.n_mag    (mag(div_n)),
		.n_neg    (div_n[DW-1]),
		.d_mag    (mag(div_d)),
		.d_neg    (div_d[DW-1]),
		.done     (div_done),
		.rem_zero (rem_zero),
		.q_trunc  (q_trunc),
		.q_floor  (q_floor),
		.q_ceil   (q_ceil),
		.r_mod    (r_mod)
	);

	always_ff @(posedge clk) begin
		unique case (cmd.op)
			dsc_pkg::OP_LOAD: begin
				a_q  <= coef_a;
				b_q  <= coef_b;
				c_q  <= rhs_c;
				xl_q <= x_low;
				xh_q <= x_high;
				yl_q <= y_low;
				yh_q <= y_high;
				r0_q <= W'(mag(sx(coef_a)));
				r1_q <= W'(mag(sx(coef_b)));
				s0_q <= (W+1)'(1);
				s1_q <= '0;
			end
			dsc_pkg::OP_EU_MUL, dsc_pkg::OP_U_MUL, dsc_pkg::OP_X_MUL: prod_q <= product;
			dsc_pkg::OP_EU_UPD: begin
				r0_q <= r1_q;
				r1_q <= r_mod[W-1:0];
				s0_q <= s1_q;
				s1_q <= s0_q - prod_q[W:0];
			end
			dsc_pkg::OP_CM_SAVE: cg_q  <= q_trunc;
			dsc_pkg::OP_A_SAVE:  ap_q  <= q_trunc;
			dsc_pkg::OP_B_SAVE:  bp_q  <= q_trunc;
			dsc_pkg::OP_S_SAVE:  pm1_q <= r_mod;
			dsc_pkg::OP_G_SAVE:  pm2_q <= r_mod;
			dsc_pkg::OP_U_SAVE:  x0_q  <= a_q[W-1] ? -r_mod : r_mod;
			dsc_pkg::OP_Y_SAVE:  y0_q  <= q_trunc;
			dsc_pkg::OP_K1_SAVE: kmin_q <= q_ceil;
			dsc_pkg::OP_K2_SAVE: kmax_q <= q_floor;
			dsc_pkg::OP_K3_SAVE: kmin_q <= (q_ceil > kmin_q) ? q_ceil : kmin_q;
			dsc_pkg::OP_K4_SAVE: kmax_q <= (q_floor < kmax_q) ? q_floor : kmax_q;
			dsc_pkg::OP_RES_ZERO: begin
				status_q <= (c_q == '0) ? dsc_pkg::ST_INF : dsc_pkg::ST_NONE;
				count_q  <= '0;
			end
			dsc_pkg::OP_RES_NOSOL: begin
				status_q <= dsc_pkg::ST_NONE;
				count_q  <= '0;
			end
			dsc_pkg::OP_RES_FIXA: begin
				status_q <= dsc_pkg::ST_FINITE;
				count_q  <= (fix_v >= yle && fix_v <= yhe) ? span(xle, xhe) : '0;
			end
			dsc_pkg::OP_RES_FIXB: begin
				status_q <= dsc_pkg::ST_FINITE;
				count_q  <= (fix_v >= xle && fix_v <= xhe) ? span(yle, yhe) : '0;
			end
			dsc_pkg::OP_RES_SPAN: begin
				status_q <= dsc_pkg::ST_FINITE;
				count_q  <= span(kmin_q, kmax_q);
			end
			default: ;
		endcase
	end

	assign stat.a_zero   = (a_q == '0);
	assign stat.b_zero   = (b_q == '0);
	assign stat.c_zero   = (c_q == '0);
	assign stat.r1_zero  = (r1_q == '0);
	assign stat.rem_zero = rem_zero;
	assign stat.div_done = div_done;
	assign status         = status_q;
	assign solution_count = count_q;

endmodule

### sv/dsc_ctrl.sv
module dsc_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  dsc_pkg::stat_t stat,
	output dsc_pkg::cmd_t  cmd,
	output logic           busy,
	output logic           done
);

	localparam logic [5:0] S_IDLE    = 6'd0;
	localparam logic [5:0] S_CHK     = 6'd1;
	localparam logic [5:0] S_EU_TEST = 6'd2;
	localparam logic [5:0] S_EU_WAIT = 6'd3;
	localparam logic [5:0] S_EU_MUL  = 6'd4;
	localparam logic [5:0] S_EU_UPD  = 6'd5;
	localparam logic [5:0] S_CM_GO   = 6'd6;
	localparam logic [5:0] S_CM_WAIT = 6'd7;
	localparam logic [5:0] S_SPLIT   = 6'd8;
	localparam logic [5:0] S_A_GO    = 6'd9;
	localparam logic [5:0] S_A_WAIT  = 6'd10;
	localparam logic [5:0] S_B_GO    = 6'd11;
	localparam logic [5:0] S_B_WAIT  = 6'd12;
	localparam logic [5:0] S_S_GO    = 6'd13;
	localparam logic [5:0] S_S_WAIT  = 6'd14;
	localparam logic [5:0] S_G_GO    = 6'd15;
	localparam logic [5:0] S_G_WAIT  = 6'd16;
	localparam logic [5:0] S_U_MUL   = 6'd17;
	localparam logic [5:0] S_U_GO    = 6'd18;
	localparam logic [5:0] S_U_WAIT  = 6'd19;
	localparam logic [5:0] S_X_MUL   = 6'd20;
	localparam logic [5:0] S_Y_GO    = 6'd21;
	localparam logic [5:0] S_Y_WAIT  = 6'd22;
	localparam logic [5:0] S_K1_GO   = 6'd23;
	localparam logic [5:0] S_K1_WAIT = 6'd24;
	localparam logic [5:0] S_K2_GO   = 6'd25;
	localparam logic [5:0] S_K2_WAIT = 6'd26;
	localparam logic [5:0] S_K3_GO   = 6'd27;
	localparam logic [5:0] S_K3_WAIT = 6'd28;
	localparam logic [5:0] S_K4_GO   = 6'd29;
	localparam logic [5:0] S_K4_WAIT = 6'd30;
	localparam logic [5:0] S_SPAN    = 6'd31;
	localparam logic [5:0] S_FIN     = 6'd32;

	logic [5:0] state_q, nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= nxt;
		end
	end

	always_comb begin
		nxt    = state_q;
		cmd.op = dsc_pkg::OP_NONE;
		unique case (state_q)
			S_IDLE: if (start) begin
				cmd.op = dsc_pkg::OP_LOAD;
				nxt    = S_CHK;
			end
			S_CHK: begin
				if (stat.a_zero && stat.b_zero) begin
					cmd.op = dsc_pkg::OP_RES_ZERO;
					nxt    = S_FIN;
				end else begin
					nxt = S_EU_TEST;
				end
			end
			S_EU_TEST: begin
				if (stat.r1_zero) begin
					nxt = S_CM_GO;
				end else begin
					cmd.op = dsc_pkg::OP_EU_DIV;
					nxt    = S_EU_WAIT;
				end
			end
			S_EU_WAIT: if (stat.div_done) nxt = S_EU_MUL;
			S_EU_MUL: begin
				cmd.op = dsc_pkg::OP_EU_MUL;
				nxt    = S_EU_UPD;
			end
			S_EU_UPD: begin
				cmd.op = dsc_pkg::OP_EU_UPD;
				nxt    = S_EU_TEST;
			end
			S_CM_GO: begin
				cmd.op = dsc_pkg::OP_CM_DIV;
				nxt    = S_CM_WAIT;
			end
			S_CM_WAIT: if (stat.div_done) begin
				if (!stat.rem_zero) begin
					cmd.op = dsc_pkg::OP_RES_NOSOL;
					nxt    = S_FIN;
				end else begin
					cmd.op = dsc_pkg::OP_CM_SAVE;
					nxt    = S_SPLIT;
				end
			end
			S_SPLIT: begin
				priority if (stat.a_zero) begin
					cmd.op = dsc_pkg::OP_RES_FIXA;
					nxt    = S_FIN;
				end else if (stat.b_zero) begin
					cmd.op = dsc_pkg::OP_RES_FIXB;
					nxt    = S_FIN;
				end else begin
					nxt = S_A_GO;
				end
			end
			S_A_GO: begin
				cmd.op = dsc_pkg::OP_A_DIV;
				nxt    = S_A_WAIT;
			end
			S_A_WAIT: if (stat.div_done) begin
				cmd.op = dsc_pkg::OP_A_SAVE;
				nxt    = S_B_GO;
			end
			S_B_GO: begin
				cmd.op = dsc_pkg::OP_B_DIV;
				nxt    = S_B_WAIT;
			end
			S_B_WAIT: if (stat.div_done) begin
				cmd.op = dsc_pkg::OP_B_SAVE;
				nxt    = S_S_GO;
			end
			S_S_GO: begin
				cmd.op = dsc_pkg::OP_S_DIV;
				nxt    = S_S_WAIT;
			end
			S_S_WAIT: if (stat.div_done) begin
				cmd.op = dsc_pkg::OP_S_SAVE;
				nxt    = S_G_GO;
			end
			S_G_GO: begin
				cmd.op = dsc_pkg::OP_G_DIV;
				nxt    = S_G_WAIT;
			end
			S_G_WAIT: if (stat.div_done) begin
				cmd.op = dsc_pkg::OP_G_SAVE;
				nxt    = S_U_MUL;
			end
			S_U_MUL: begin
				cmd.op = dsc_pkg::OP_U_MUL;
				nxt    = S_U_GO;
			end
			S_U_GO: begin
				cmd.op = dsc_pkg::OP_U_DIV;
				nxt    = S_U_WAIT;
			end
			S_U_WAIT: if (stat.div_done) begin
				cmd.op = dsc_pkg::OP_U_SAVE;
				nxt    = S_X_MUL;
			end
			S_X_MUL: begin
				cmd.op = dsc_pkg::OP_X_MUL;
				nxt    = S_Y_GO;
			end
			S_Y_GO: begin
				cmd.op = dsc_pkg::OP_Y_DIV;
				nxt    = S_Y_WAIT;
			end
			S_Y_WAIT: if (stat.div_done) begin
				cmd.op = dsc_pkg::OP_Y_SAVE;
				nxt    = S_K1_GO;
			end
			S_K1_GO: begin
				cmd.op = dsc_pkg::OP_K1_DIV;
				nxt    = S_K1_WAIT;
			end
			S_K1_WAIT: if (stat.div_done) begin
				cmd.op = dsc_pkg::OP_K1_SAVE;
				nxt    = S_K2_GO;
			end
			S_K2_GO: begin
				cmd.op = dsc_pkg::OP_K2_DIV;
				nxt    = S_K2_WAIT;
			end
			S_K2_WAIT: if (stat.div_done) begin
				cmd.op = dsc_pkg::OP_K2_SAVE;
				nxt    = S_K3_GO;
			end
			S_K3_GO: begin
				cmd.op = dsc_pkg::OP_K3_DIV;
				nxt    = S_K3_WAIT;
			end
			S_K3_WAIT: if (stat.div_done) begin
				cmd.op = dsc_pkg::OP_K3_SAVE;
				nxt    = S_K4_GO;
			end
			S_K4_GO: begin
				cmd.op = dsc_pkg::OP_K4_DIV;
				nxt    = S_K4_WAIT;
			end
			S_K4_WAIT: if (stat.div_done) begin
				cmd.op = dsc_pkg::OP_K4_SAVE;
				nxt    = S_SPAN;
			end
			S_SPAN: begin
				cmd.op = dsc_pkg::OP_RES_SPAN;
				nxt    = S_FIN;
			end
			S_FIN: nxt = S_IDLE;
			default: nxt = S_IDLE;
		endcase
	end

	assign busy = (state_q != S_IDLE);
	assign done = (state_q == S_FIN);

`ifndef SYNTH
	a_fin_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !busy) else $error("result beat not followed by idle");
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy && !done)) else $error("accepted beat not taken up");
	a_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		stat.div_done |-> (state_q == S_EU_WAIT || state_q == S_CM_WAIT ||
		state_q == S_A_WAIT || state_q == S_B_WAIT || state_q == S_S_WAIT ||
		state_q == S_G_WAIT || state_q == S_U_WAIT || state_q == S_Y_WAIT ||
		state_q == S_K1_WAIT || state_q == S_K2_WAIT || state_q == S_K3_WAIT ||
		state_q == S_K4_WAIT)) else $error("divider result outside a wait state");
`endif

endmodule

### sv/diophantine_solution_counter_core.sv
// channel   handshake        payload
// command   start / busy     coef_a coef_b rhs_c x_low x_high y_low y_high
// result    done (strobe)    status solution_count
//
// A beat is taken when start is high and busy is low; one result beat follows.
// Each beat runs N Euclid steps (at most about 46) and then the remaining divisions, all on
// the one-bit-per-cycle divider that every division shares. A zero coefficient ends early.
// Asynchronous active-low reset returns to idle; busy stays high until done.
// done is high for one cycle and cannot be stalled.
module diophantine_solution_counter_core #(
	parameter int COEF_WIDTH = 32
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	output logic                             busy,
	input  logic signed [COEF_WIDTH-1:0]     coef_a,
	input  logic signed [COEF_WIDTH-1:0]     coef_b,
	input  logic signed [COEF_WIDTH-1:0]     rhs_c,
	input  logic signed [COEF_WIDTH-1:0]     x_low,
	input  logic signed [COEF_WIDTH-1:0]     x_high,
	input  logic signed [COEF_WIDTH-1:0]     y_low,
	input  logic signed [COEF_WIDTH-1:0]     y_high,
	output logic                             done,
	output logic [1:0]                       status,
	output logic [dsc_pkg::CNT_W-1:0]        solution_count
);

	dsc_pkg::cmd_t  cmd;
	dsc_pkg::stat_t stat;

	dsc_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	dsc_dp #(.W(COEF_WIDTH)) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.coef_a         (coef_a),
		.coef_b         (coef_b),
		.rhs_c          (rhs_c),
		.x_low          (x_low),
		.x_high         (x_high),
		.y_low          (y_low),
		.y_high         (y_high),
		.stat           (stat),
		.status         (status),
		.solution_count (solution_count)
	);

endmodule

### test/tb_top.sv
module tb_top;

	typedef struct {
		logic signed [31:0] a, b, c, xl, xh, yl, yh;
	} eqn_t;

	typedef struct {
		logic [1:0]                st;
		logic [dsc_pkg::CNT_W-1:0] cnt;
	} tally_t;

	logic                      clk;
	logic                      arst_n;
	logic                      start;
	logic                      busy;
	logic signed [31:0]        coef_a, coef_b, rhs_c, x_low, x_high, y_low, y_high;
	logic                      done;
	logic [1:0]                status;
	logic [dsc_pkg::CNT_W-1:0] solution_count;

	eqn_t   pending_eqns[$];
	tally_t expected_tallies[$];
	int     errors, beats_in, beats_out, drain_at, gap;
	int     n_fin, n_none, n_inf;
	longint cycles;
	bit     drain_req;

	diophantine_solution_counter_core #(.COEF_WIDTH(32)) u_top (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.coef_a(coef_a), .coef_b(coef_b), .rhs_c(rhs_c),
		.x_low(x_low), .x_high(x_high), .y_low(y_low), .y_high(y_high),
		.done(done), .status(status), .solution_count(solution_count)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic longint fdiv(longint n, longint d);
		longint q;
		q = n / d;
		if ((n % d != 0) && ((n < 0) != (d < 0)))
			q = q - 1;
		return q;
	endfunction

	function automatic longint cdiv(longint n, longint d);
		return -fdiv(-n, d);
	endfunction

	function automatic longint pmod(longint v, longint m);
		longint r;
		r = v % m;
		return (r < 0) ? r + m : r;
	endfunction

	function automatic longint mag(longint v);
		return (v < 0) ? -v : v;
	endfunction

	function automatic longint width_of(longint lo, longint hi);
		return (lo > hi) ? 0 : hi - lo + 1;
	endfunction

	// k range with lo <= base + k*d <= hi
	function automatic void k_bounds(input longint lo, hi, base, d,
		output longint kmin, kmax);
		if (d > 0) begin
			kmin = cdiv(lo - base, d);
			kmax = fdiv(hi - base, d);
		end else begin
			kmin = cdiv(hi - base, d);
			kmax = fdiv(lo - base, d);
		end
	endfunction

	function automatic tally_t count_solutions(eqn_t e);
		tally_t r;
		longint a, b, c, r0, r1, s0, s1, q, t, g, ap, bp, m, u0, x0, y0, v;
		longint k1, k2, k3, k4, w;
		a = e.a; b = e.b; c = e.c;
		r.st = dsc_pkg::ST_FINITE;
		r.cnt = '0;
		w = 0;
		if (a == 0 && b == 0) begin
			r.st = (c == 0) ? dsc_pkg::ST_INF : dsc_pkg::ST_NONE;
		end else begin
			r0 = mag(a); r1 = mag(b); s0 = 1; s1 = 0;
			while (r1 != 0) begin
				q = r0 / r1;
				t = r0 - q * r1; r0 = r1; r1 = t;
				t = s0 - q * s1; s0 = s1; s1 = t;
			end
			g = r0;
			if (pmod(c, g) != 0) begin
				r.st = dsc_pkg::ST_NONE;
			end else if (a == 0) begin
				v = c / b;
				if (v >= e.yl && v <= e.yh)
					w = width_of(e.xl, e.xh);
			end else if (b == 0) begin
				v = c / a;
				if (v >= e.xl && v <= e.xh)
					w = width_of(e.yl, e.yh);
			end else begin
				ap = a / g; bp = b / g; m = mag(bp);
				u0 = (pmod(s0, m) * pmod(c / g, m)) % m;
				x0 = (a < 0) ? -u0 : u0;
				y0 = (c - a * x0) / b;
				k_bounds(e.xl, e.xh, x0, bp, k1, k2);
				k_bounds(e.yl, e.yh, y0, -ap, k3, k4);
				w = width_of((k1 > k3) ? k1 : k3, (k2 < k4) ? k2 : k4);
			end
		end
		r.cnt = w[dsc_pkg::CNT_W-1:0];
		return r;
	endfunction

	function automatic logic signed [31:0] rnd32();
		return $signed($urandom);
	endfunction

	function automatic logic signed [31:0] rnd_small(int lim);
		return $urandom_range(0, 2 * lim) - lim;
	endfunction

	function automatic eqn_t mk(int a, b, c, xl, xh, yl, yh);
		eqn_t e;
		e.a = a; e.b = b; e.c = c; e.xl = xl; e.xh = xh; e.yl = yl; e.yh = yh;
		return e;
	endfunction

	function automatic eqn_t random_eqn();
		eqn_t e;
		int   mode, lim, sx, sy;
		mode = $urandom_range(0, 9);
		lim = ($urandom_range(0, 3) == 0) ? 1 << 20 : 60;
		e.a = rnd_small(lim);
		e.b = rnd_small(lim);
		sx = rnd_small(1000);
		sy = rnd_small(1000);
		e.c = e.a * sx + e.b * sy;
		e.xl = sx - $urandom_range(0, 3000);
		e.xh = sx + $urandom_range(0, 3000);
		e.yl = sy - $urandom_range(0, 3000);
		e.yh = sy + $urandom_range(0, 3000);
		case (mode)
			5, 6: e = mk(rnd32(), rnd32(), rnd32(), rnd32(), rnd32(), rnd32(), rnd32());
			7: begin
				e.xl = rnd32(); e.xh = rnd32(); e.yl = rnd32(); e.yh = rnd32();
			end
			8: begin
				if ($urandom_range(0, 1)) e.a = 0; else e.b = 0;
				if ($urandom_range(0, 1)) e.c = rnd32();
			end
			9: e.c = rnd_small(5000);
			default: if ($urandom_range(0, 7) == 0) begin
				e.xl = e.xh + $urandom_range(1, 9);
			end
		endcase
		return e;
	endfunction

	function automatic int pick_gap();
		if ($urandom_range(0, 9) < 7) return $urandom_range(0, 2);
		return $urandom_range(5, 60);
	endfunction

	// driver: start drops after each beat
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			{coef_a, coef_b, rhs_c, x_low, x_high, y_low, y_high} <= '0;
			gap <= 0;
		end else if (start && !busy) begin
			expected_tallies.push_back(count_solutions(pending_eqns.pop_front()));
			beats_in <= beats_in + 1;
			start <= 1'b0;
			gap <= ((beats_in / 40) % 2 == 1) ? 0 : pick_gap();
		end else if (!start) begin
			if (gap > 0) begin
				gap <= gap - 1;
			end else if (beats_in == drain_at && expected_tallies.size() != 0) begin
				drain_req <= 1'b1;
			end else if (pending_eqns.size() != 0) begin
				coef_a <= pending_eqns[0].a;
				coef_b <= pending_eqns[0].b;
				rhs_c <= pending_eqns[0].c;
				x_low <= pending_eqns[0].xl;
				x_high <= pending_eqns[0].xh;
				y_low <= pending_eqns[0].yl;
				y_high <= pending_eqns[0].yh;
				start <= 1'b1;
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		if (arst_n && done) begin
			beats_out <= beats_out + 1;
			if (expected_tallies.size() == 0) begin
				$display("%0t: unexpected result status=%0d count=%0d", $time, status,
					solution_count);
				errors <= errors + 1;
			end else begin
				tally_t x;
				x = expected_tallies.pop_front();
				if (x.st != status || x.cnt != solution_count) begin
					$display("%0t: mismatch exp status=%0d count=%0d act status=%0d count=%0d",
						$time, x.st, x.cnt, status, solution_count);
					errors <= errors + 1;
				end
				case (x.st)
					dsc_pkg::ST_FINITE: n_fin <= n_fin + 1;
					dsc_pkg::ST_NONE: n_none <= n_none + 1;
					default: n_inf <= n_inf + 1;
				endcase
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 4000000) begin
			$display("%0t: timeout", $time);
			$display("TEST FAILED");
			$finish;
		end
	end

	initial begin
		errors = 0; beats_in = 0; beats_out = 0; cycles = 0;
		n_fin = 0; n_none = 0; n_inf = 0;
		drain_req = 0;
		drain_at = 150;
		arst_n = 1'b0;
		pending_eqns.push_back(mk(0, 0, 0, 5, 1, 5, 1));
		pending_eqns.push_back(mk(0, 0, 7, 0, 9, 0, 9));
		pending_eqns.push_back(mk(2, 4, 3, -9, 9, -9, 9));
		pending_eqns.push_back(mk(0, 3, 6, -2147483648, 2147483647, 0, 5));
		pending_eqns.push_back(mk(0, 3, 6, 0, 9, 3, 9));
		pending_eqns.push_back(mk(-4, 0, 8, -5, 5, -2147483648, 2147483647));
		pending_eqns.push_back(mk(-4, 0, 8, 0, 5, 1, 9));
		pending_eqns.push_back(mk(3, 5, 7, 9, -9, -9, 9));
		pending_eqns.push_back(mk(3, 5, 7, -9, 9, 9, -9));
		pending_eqns.push_back(mk(1, 1, 0, -2147483648, 2147483647, -2147483648, 2147483647));
		pending_eqns.push_back(mk(-2147483648, -2147483648, -2147483648, -3, 3, -3, 3));
		pending_eqns.push_back(mk(2147483647, -2147483648, 1, -2147483648, 2147483647,
			-2147483648, 2147483647));
		pending_eqns.push_back(mk(-2147483648, 2147483647, 2147483647, -2147483648,
			2147483647, -2147483648, 2147483647));
		pending_eqns.push_back(mk(1836311903, 1134903170, 1, -2147483648, 2147483647,
			-2147483648, 2147483647));
		pending_eqns.push_back(mk(-6, 10, -4, -100, 100, -100, 100));
		pending_eqns.push_back(mk(6, -10, 4, -100, 100, -100, 100));
		pending_eqns.push_back(mk(-1, -1, -2147483648, -2147483648, 2147483647, 0, 0));
		pending_eqns.push_back(mk(7, 7, 7, 0, 0, 1, 1));
		pending_eqns.push_back(mk(0, -1, -2147483648, 0, 0, -2147483648, -2147483648));
		repeat (290) pending_eqns.push_back(random_eqn());
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		wait (pending_eqns.size() == 0 && !start);
		wait (expected_tallies.size() == 0);
		repeat (3000) @(posedge clk);
		$display("%0d commands sent, %0d results: %0d finite, %0d no solution, %0d infinite",
			beats_in, beats_out, n_fin, n_none, n_inf);
		$display("covered zero coefficients, empty ranges and extremes%s",
			drain_req ? ", with a drain pause" : "");
		if (errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
